>>> design/websocket_frame_deframer_top_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is held.
`define WFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> design/wfd_pkg.sv
// Package: types, codes and constants of the frame deframer.
`default_nettype none
package wfd_pkg;

    localparam int WFD_LENGTH_BITS  = 64;
    localparam int WFD_QUEUE_DEPTH  = 4;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [7:0] PONG_HEADER = 8'h8A;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } wfd_phase_t;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_PONG  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_EMPTY = 2'd3
    } wfd_kind_t;

    typedef struct packed {
        wfd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } wfd_result_t;

    // One queued request: one or two results.
    typedef struct packed {
        wfd_result_t r0;
        wfd_result_t r1;
        logic        pair;
    } wfd_cmd_t;

endpackage
`default_nettype wire

>>> design/wfd_front.sv
// Front end: header parser, mask key capture and payload unmasking.
`default_nettype none
`include "websocket_frame_deframer_top_assert.svh"
module wfd_front #(
    parameter int LENGTH_BITS = wfd_pkg::WFD_LENGTH_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             cfg_we,
    input  wire logic             cfg_wdata,
    input  wire logic             q_full,
    output logic                  q_push,
    output wfd_pkg::wfd_cmd_t     q_push_data
);
    import wfd_pkg::*;

    logic                   enable_reg;
    logic                   closed_reg,   closed_next;
    wfd_phase_t             phase_reg,    phase_next;
    logic [3:0]             opcode_reg,   opcode_next;
    logic                   mask_reg,     mask_next;
    logic [LENGTH_BITS-1:0] rem_reg,      rem_next;
    logic [2:0]             ext_left_reg, ext_left_next;
    logic [31:0]            key_reg,      key_next;
    logic [1:0]             kidx_reg,     kidx_next;

    logic                   accept;
    logic                   len_done;
    logic                   hdr_done;
    logic [LENGTH_BITS-1:0] len_val;
    logic [6:0]             len7;
    logic [7:0]             key_byte;
    logic [7:0]             plain;
    logic                   pay_last;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign len7     = s_tdata[6:0];
    assign plain    = s_tdata ^ key_byte;
    assign pay_last = (rem_reg == LENGTH_BITS'(1));

    always_comb begin
        unique case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        if (!mask_reg) begin
            key_byte = 8'h00;
        end
    end

    always_comb begin
        closed_next   = closed_reg;
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        mask_next     = mask_reg;
        rem_next      = rem_reg;
        ext_left_next = ext_left_reg;
        key_next      = key_reg;
        kidx_next     = kidx_reg;
        len_done      = 1'b0;
        hdr_done      = 1'b0;
        len_val       = rem_reg;
        q_push        = 1'b0;
        q_push_data   = '0;

        if (accept && enable_reg && !closed_reg) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    opcode_next = s_tdata[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    mask_next = s_tdata[7];
                    rem_next  = '0;
                    if (len7 == LEN7_EXT16) begin
                        ext_left_next = 3'd1;
                        phase_next    = PH_EXT;
                    end else if (len7 == LEN7_EXT64) begin
                        ext_left_next = 3'd7;
                        phase_next    = PH_EXT;
                    end else begin
                        len_val  = LENGTH_BITS'(len7);
                        rem_next = len_val;
                        len_done = 1'b1;
                    end
                end
                PH_EXT: begin
                    // saturate once the top byte would be shifted out
                    if (|rem_reg[LENGTH_BITS-1 -: 8]) begin
                        len_val = '1;
                    end else begin
                        len_val = {rem_reg[LENGTH_BITS-9:0], s_tdata};
                    end
                    rem_next = len_val;
                    if (ext_left_reg == 3'd0) begin
                        len_done = 1'b1;
                    end else begin
                        ext_left_next = ext_left_reg - 3'd1;
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], s_tdata};
                    if (kidx_reg == 2'd3) begin
                        hdr_done = 1'b1;
                    end else begin
                        kidx_next = kidx_reg + 2'd1;
                    end
                end
                PH_PAY: begin
                    kidx_next = kidx_reg + 2'd1;
                    rem_next  = rem_reg - LENGTH_BITS'(1);
                    if (pay_last) begin
                        phase_next = PH_HDR0;
                    end
                    if (opcode_reg == OP_TEXT) begin
                        q_push              = 1'b1;
                        q_push_data.r0.kind = KIND_TEXT;
                        q_push_data.r0.data = plain;
                        q_push_data.r0.last = pay_last;
                    end else if (opcode_reg == OP_PING) begin
                        q_push              = 1'b1;
                        q_push_data.r0.kind = KIND_PONG;
                        q_push_data.r0.data = plain;
                        q_push_data.r0.last = pay_last;
                    end else if (opcode_reg == OP_CLOSE && pay_last) begin
                        closed_next         = 1'b1;
                        q_push              = 1'b1;
                        q_push_data.r0.kind = KIND_CLOSE;
                        q_push_data.r0.last = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            if (len_done) begin
                if (mask_next) begin
                    phase_next = PH_MASK;
                    kidx_next  = 2'd0;
                    key_next   = '0;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                kidx_next = 2'd0;
                if (len_val == '0) begin
                    phase_next = PH_HDR0;
                    if (opcode_reg == OP_TEXT) begin
                        q_push              = 1'b1;
                        q_push_data.r0.kind = KIND_EMPTY;
                        q_push_data.r0.last = 1'b1;
                    end else if (opcode_reg == OP_PING) begin
                        q_push              = 1'b1;
                        q_push_data.pair    = 1'b1;
                        q_push_data.r0.kind = KIND_PONG;
                        q_push_data.r0.data = PONG_HEADER;
                        q_push_data.r1.kind = KIND_PONG;
                        q_push_data.r1.last = 1'b1;
                    end else if (opcode_reg == OP_CLOSE) begin
                        closed_next         = 1'b1;
                        q_push              = 1'b1;
                        q_push_data.r0.kind = KIND_CLOSE;
                        q_push_data.r0.last = 1'b1;
                    end
                end else begin
                    phase_next = PH_PAY;
                    if (opcode_reg == OP_PING) begin
                        // pong length byte: low 8 bits of the length
                        q_push              = 1'b1;
                        q_push_data.pair    = 1'b1;
                        q_push_data.r0.kind = KIND_PONG;
                        q_push_data.r0.data = PONG_HEADER;
                        q_push_data.r1.kind = KIND_PONG;
                        q_push_data.r1.data = len_val[7:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            closed_reg   <= 1'b0;
            phase_reg    <= PH_HDR0;
            opcode_reg   <= '0;
            mask_reg     <= 1'b0;
            rem_reg      <= '0;
            ext_left_reg <= '0;
            key_reg      <= '0;
            kidx_reg     <= '0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            closed_reg   <= closed_next;
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            mask_reg     <= mask_next;
            rem_reg      <= rem_next;
            ext_left_reg <= ext_left_next;
            key_reg      <= key_next;
            kidx_reg     <= kidx_next;
        end
    end

    `WFD_ASSERT_NEXT(a_closed_sticks, aclk, aresetn, closed_reg, closed_reg)
    `WFD_ASSERT_NOW(a_pay_nonzero, aclk, aresetn, phase_reg == PH_PAY, rem_reg != '0)
    `WFD_ASSERT_NOW(a_pair_is_pong, aclk, aresetn, q_push && q_push_data.pair,
                    q_push_data.r0.kind == KIND_PONG && q_push_data.r1.kind == KIND_PONG)

endmodule
`default_nettype wire

>>> design/wfd_queue.sv
// Request queue between the parser and the output stage.
`default_nettype none
module wfd_queue #(
    parameter int DEPTH = wfd_pkg::WFD_QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire wfd_pkg::wfd_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output wfd_pkg::wfd_cmd_t      head
);
    import wfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wfd_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        priority if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> design/wfd_back.sv
// Back end: splits queued requests into results and drives the output register.
`default_nettype none
`include "websocket_frame_deframer_top_assert.svh"
module wfd_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire wfd_pkg::wfd_cmd_t q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import wfd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    wfd_result_t out_reg,       out_next;
    logic        sel_reg,       sel_next;
    logic        load;

    assign load = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sel_next       = sel_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = 1'b1;
            out_next       = sel_reg ? q_head.r1 : q_head.r0;
            if (q_head.pair && !sel_reg) begin
                sel_next = 1'b1;
            end else begin
                sel_next = 1'b0;
                q_pop    = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    `WFD_ASSERT_NOW(a_pop_on_load, aclk, aresetn, q_pop, load)
    `WFD_ASSERT_NOW(a_sel_has_pair, aclk, aresetn, sel_reg, q_valid && q_head.pair)
    `WFD_ASSERT_NEXT(a_pair_second, aclk, aresetn, load && !sel_reg && q_head.pair, sel_reg)

endmodule
`default_nettype wire

>>> design/websocket_frame_deframer_top.sv
// Top level of the WebSocket receive-side frame deframer.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+---------------------------------
//   s_ (rx)   | in        | s_tvalid/s_tready  | s_tdata[7:0] = rx_byte
//   m_ (res)  | out       | m_tvalid/m_tready  | m_tdata = out_byte, m_tuser =
//             |           |                    | out_kind, m_tlast = out_last
//   cfg       | in        | cfg_we             | cfg_wdata = framing_enabled
//
// One received byte is taken every cycle while the request queue has room; the
// parser finishes each byte in the cycle it is accepted.
// Results leave one per cycle from a registered output stage while m_tready
// is high; a ping header makes two results, so the output port sets the
// sustained rate there and the QUEUE_DEPTH-entry queue absorbs the burst.
// With an idle output, a result is registered first in the queue and then in
// the output register before it is valid.
// Reset (aresetn low, synchronous) clears parser state, queue and output stage;
// framing starts disabled.
`default_nettype none
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = wfd_pkg::WFD_LENGTH_BITS,  // 16..64
    parameter int QUEUE_DEPTH = wfd_pkg::WFD_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,     // [7:0] out_byte
    output logic [1:0]      m_tuser,     // [1:0] out_kind
    output logic            m_tlast,     // out_last
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata    // framing_enabled
);
    import wfd_pkg::*;

    // parser -> queue
    logic     q_push;
    wfd_cmd_t q_push_data;
    logic     q_full;
    // queue -> output stage
    logic     q_pop;
    logic     q_valid;
    wfd_cmd_t q_head;

    wfd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // decouples the parser from output back-pressure
    wfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    wfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
